[design/bqlp_pkg.sv]
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared types and constants for the biquad low-pass with warm-up.
// ----------------------------------------------------------------------------
package bqlp_pkg;

  // Default parameter values
  localparam int DEF_WARMUP_SAMPLES = 100;
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;

  // Fixed formats
  localparam int COEF_W     = 18;  // signed Q3.14 coefficient
  localparam int HIST_FRAC  = 8;   // fraction bits of the output history
  localparam int WARM_CNT_W = 7;   // covers any warm-up length up to 127
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_t;

  // One full coefficient set
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

endpackage

[design/biquad_lowpass_with_warmup_core.sv]
// ----------------------------------------------------------------------------
// biquad_lowpass_with_warmup_core
// Second-order low-pass biquad with a pass-through warm-up period.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample_in) takes one signed sample
//   per request. Output channel (out_valid / out_stall / filtered_out,
//   warming_up) returns exactly one result per sample, in order.
//   The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes the coefficients b0, b1, b2, a1, a2 (indexes 0..4, Q3.14); other
//   indexes are ignored. cfg_ready is always high. Write only while idle.
//   A sample passes through the input stage, then the result register.
//   The input takes one sample per cycle as long as out_stall stays low.
//   The recursive loop closes through the result stage: a1*y1 + a2*y2,
//   round and clamp are combinational ahead of the result register.
//   For the first WARMUP_SAMPLES samples the input is passed through and
//   warming_up is set; the filter runs from then on.
//   Reset clears the histories, the warm-up count and both valid flags,
//   and restores b0 = 1.0 with all other coefficients zero.
//   When out_stall holds the result, one more sample is still taken into
//   the input stage; after that in_stall rises until the result drains.
// ----------------------------------------------------------------------------
module biquad_lowpass_with_warmup_core #(
  parameter int WARMUP_SAMPLES = bqlp_pkg::DEF_WARMUP_SAMPLES,
  parameter int SAMPLE_WIDTH   = bqlp_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = bqlp_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_out,
  output logic                           warming_up,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bqlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bqlp_pkg::COEF_W-1:0]    cfg_data
);
  import bqlp_pkg::*;

  localparam int FF_W = SAMPLE_WIDTH + COEF_W + 2;

  coef_set_t                      coef;
  logic                           advance;
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_x;
  logic signed [FF_W-1:0]         s1_ff;
  logic                           s1_warm;

  // Coefficient registers
  bqlp_coef_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Input stage with feed-forward sum
  bqlp_feedfwd #(
    .WARMUP_SAMPLES (WARMUP_SAMPLES),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_feedfwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .coef      (coef),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_x      (s1_x),
    .s1_ff     (s1_ff),
    .s1_warm   (s1_warm)
  );

  // Feedback and result stage
  bqlp_feedback #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_feedback (
    .clk          (clk),
    .rst          (rst),
    .coef         (coef),
    .s1_valid     (s1_valid),
    .s1_x         (s1_x),
    .s1_ff        (s1_ff),
    .s1_warm      (s1_warm),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered_out (filtered_out),
    .warming_up   (warming_up)
  );

endmodule

[design/bqlp_coef_regs.sv]
// ----------------------------------------------------------------------------
// bqlp_coef_regs
// Coefficient register file written through the configuration channel.
// ----------------------------------------------------------------------------
module bqlp_coef_regs #(
  parameter int COEF_FRAC_BITS = bqlp_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bqlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqlp_pkg::COEF_W-1:0]      cfg_data,
  output bqlp_pkg::coef_set_t              coef
);
  import bqlp_pkg::*;

  // b0 resets to unity gain
  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1) << COEF_FRAC_BITS;

  logic cfg_write;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // Register update; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= B0_RESET;
      coef.b1 <= '0;
      coef.b2 <= '0;
      coef.a1 <= '0;
      coef.a2 <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_B0:  coef.b0 <= cfg_data;
        REG_B1:  coef.b1 <= cfg_data;
        REG_B2:  coef.b2 <= cfg_data;
        REG_A1:  coef.a1 <= cfg_data;
        REG_A2:  coef.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[design/bqlp_feedfwd.sv]
// ----------------------------------------------------------------------------
// bqlp_feedfwd
// Input stage: takes a request, shifts the input history, tracks warm-up
// and registers the feed-forward sum b0*x + b1*x1 + b2*x2.
// ----------------------------------------------------------------------------
module bqlp_feedfwd #(
  parameter int WARMUP_SAMPLES = bqlp_pkg::DEF_WARMUP_SAMPLES,
  parameter int SAMPLE_WIDTH   = bqlp_pkg::DEF_SAMPLE_WIDTH,
  localparam int FF_W          = SAMPLE_WIDTH + bqlp_pkg::COEF_W + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  bqlp_pkg::coef_set_t            coef,
  input  logic                           advance,
  output logic                           s1_valid,
  output logic signed [SAMPLE_WIDTH-1:0] s1_x,
  output logic signed [FF_W-1:0]         s1_ff,
  output logic                           s1_warm
);
  import bqlp_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam logic [WARM_CNT_W-1:0] WARM_LAST = WARM_CNT_W'(WARMUP_SAMPLES);

  logic                           take;
  logic                           warm_now;
  logic signed [SAMPLE_WIDTH-1:0] prev_in_1;
  logic signed [SAMPLE_WIDTH-1:0] prev_in_2;
  logic [WARM_CNT_W-1:0]          warmup_count;
  logic signed [PROD_W-1:0]       prod_0;
  logic signed [PROD_W-1:0]       prod_1;
  logic signed [PROD_W-1:0]       prod_2;
  logic signed [FF_W-1:0]         ff_next;

  // Handshake: hold off only while the stage is full and cannot drain
  assign in_stall = s1_valid & ~advance;
  assign take     = in_valid & ~in_stall;
  assign warm_now = warmup_count < WARM_LAST;

  // Feed-forward products and sum
  always_comb begin
    prod_0  = sample_in * coef.b0;
    prod_1  = prev_in_1 * coef.b1;
    prod_2  = prev_in_2 * coef.b2;
    ff_next = FF_W'(prod_0) + FF_W'(prod_1) + FF_W'(prod_2);
  end

  // Stage occupancy, history and warm-up count
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      prev_in_1    <= '0;
      prev_in_2    <= '0;
      warmup_count <= '0;
    end else begin
      if (take) begin
        s1_valid  <= 1'b1;
        prev_in_1 <= sample_in;
        prev_in_2 <= prev_in_1;
        if (warm_now) begin
          warmup_count <= warmup_count + WARM_CNT_W'(1);
        end
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_x    <= sample_in;
      s1_ff   <= ff_next;
      s1_warm <= warm_now;
    end
  end

endmodule

[design/bqlp_feedback.sv]
// ----------------------------------------------------------------------------
// bqlp_feedback
// Output stage: subtracts the feedback terms, rounds and saturates the new
// history value, shifts the output history and holds the result register.
// ----------------------------------------------------------------------------
module bqlp_feedback #(
  parameter int SAMPLE_WIDTH   = bqlp_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = bqlp_pkg::DEF_COEF_FRAC_BITS,
  localparam int FF_W          = SAMPLE_WIDTH + bqlp_pkg::COEF_W + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bqlp_pkg::coef_set_t            coef,
  input  logic                           s1_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] s1_x,
  input  logic signed [FF_W-1:0]         s1_ff,
  input  logic                           s1_warm,
  output logic                           advance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_out,
  output logic                           warming_up
);
  import bqlp_pkg::*;

  localparam int HIST_W = SAMPLE_WIDTH + HIST_FRAC;
  localparam int MUL_W  = HIST_W + COEF_W;
  localparam int ACC_W  = FF_W + HIST_FRAC + 3;
  localparam int OUT_W  = HIST_W + 1;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HIST_MAX = (ACC_W'(1) <<< (HIST_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HIST_MIN = -(ACC_W'(1) <<< (HIST_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_HALF = OUT_W'(1) <<< (HIST_FRAC - 1);
  localparam logic signed [OUT_W-1:0] SMP_MAX  = (OUT_W'(1) <<< (SAMPLE_WIDTH - 1)) - OUT_W'(1);
  localparam logic signed [OUT_W-1:0] SMP_MIN  = -(OUT_W'(1) <<< (SAMPLE_WIDTH - 1));

  logic signed [HIST_W-1:0]       prev_out_1;
  logic signed [HIST_W-1:0]       prev_out_2;
  logic signed [MUL_W-1:0]        fb_1;
  logic signed [MUL_W-1:0]        fb_2;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_rnd;
  logic signed [HIST_W-1:0]       y_filt;
  logic signed [OUT_W-1:0]        y_rnd;
  logic signed [SAMPLE_WIDTH-1:0] res_filt;
  logic signed [HIST_W-1:0]       y_next;
  logic signed [SAMPLE_WIDTH-1:0] res_next;

  // Move forward when the result register is empty or being drained
  assign advance = s1_valid & (~out_valid | ~out_stall);

  // Feedback sum, rounding to Q16.8 and saturation
  always_comb begin
    fb_1    = coef.a1 * prev_out_1;
    fb_2    = coef.a2 * prev_out_2;
    acc     = (ACC_W'(s1_ff) <<< HIST_FRAC) - ACC_W'(fb_1) - ACC_W'(fb_2);
    acc_rnd = (acc + ACC_HALF) >>> COEF_FRAC_BITS;
    if (acc_rnd > HIST_MAX) begin
      y_filt = HIST_MAX[HIST_W-1:0];
    end else if (acc_rnd < HIST_MIN) begin
      y_filt = HIST_MIN[HIST_W-1:0];
    end else begin
      y_filt = acc_rnd[HIST_W-1:0];
    end
  end

  // Integer output: round away the history fraction, then clamp
  always_comb begin
    y_rnd = (OUT_W'(y_filt) + OUT_HALF) >>> HIST_FRAC;
    if (y_rnd > SMP_MAX) begin
      res_filt = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_rnd < SMP_MIN) begin
      res_filt = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      res_filt = y_rnd[SAMPLE_WIDTH-1:0];
    end
  end

  // Warm-up passes the sample through
  always_comb begin
    if (s1_warm) begin
      y_next   = HIST_W'(s1_x) <<< HIST_FRAC;
      res_next = s1_x;
    end else begin
      y_next   = y_filt;
      res_next = res_filt;
    end
  end

  // Output history and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out_1 <= '0;
      prev_out_2 <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        prev_out_1 <= y_next;
        prev_out_2 <= prev_out_1;
        out_valid  <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_out <= res_next;
      warming_up   <= s1_warm;
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the biquad low-pass with warm-up. Samples are sent
// as requests with random bursts and gaps while the result side stalls on its
// own pattern. A bit-accurate filter model predicts each result, and every
// result that leaves the block is compared with it in order. Covered: the
// warm-up pass-through, reset coefficients, ignored register indexes,
// rounding of halves, saturation, sensor-like streams and back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqlp_pkg::*;

  localparam int WARMUP_LEN   = DEF_WARMUP_SAMPLES;
  localparam int SAMPLE_W     = DEF_SAMPLE_WIDTH;
  localparam int COEF_FRAC    = DEF_COEF_FRAC_BITS;
  localparam int HIST_W       = SAMPLE_W + HIST_FRAC;
  localparam int COEF_ONE     = 1 << COEF_FRAC;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SMAX         = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SMIN         = -(1 << (SAMPLE_W - 1));
  localparam logic signed [COEF_W-1:0] CMAX = COEF_W'((1 << (COEF_W - 1)) - 1);
  localparam logic signed [COEF_W-1:0] CMIN = COEF_W'(-(1 << (COEF_W - 1)));

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    warm;
  } filt_result_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  // DUT ports
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  sample_t              sample_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sample_t              filtered_out;
  logic                 warming_up;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data  = '0;

  // Filter model state
  coef_set_t coefs = '{b0: COEF_W'(COEF_ONE), b1: '0, b2: '0, a1: '0, a2: '0};
  longint    hist_x1 = 0;
  longint    hist_x2 = 0;
  longint    hist_y1 = 0;
  longint    hist_y2 = 0;
  int        warm_count = 0;

  filt_result_t filtered_fifo[$];

  // Traffic control and bookkeeping
  bit          gap_enable   = 1'b1;
  int          burst_left   = 0;
  stall_mode_t stall_mode   = STALL_NONE;
  int          hold_request = 0;
  int          hold_left    = 0;
  logic [7:0]  stall_pattern = 8'b0110_0100;
  int          cycle_count  = 0;
  int          mismatch_count = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          coef_sets_loaded = 0;

  biquad_lowpass_with_warmup_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered_out (filtered_out),
    .warming_up   (warming_up),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               filtered_fifo.size());
      $display("** biquad_lowpass_with_warmup_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Filter model
  // ---------------------------------------------------------------------------
  // add half an LSB, then floor: halves go toward plus infinity
  function automatic longint round_half_up(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_signed(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic filt_result_t biquad_step(input sample_t x);
    filt_result_t r;
    longint xs;
    longint acc;
    longint y;
    xs = longint'(x);
    r.warm = (warm_count < WARMUP_LEN);
    if (r.warm) begin
      // pass-through; history takes the input as Q16.8
      y = xs <<< HIST_FRAC;
      r.value = x;
      warm_count++;
    end else begin
      acc = (longint'(coefs.b0) * xs + longint'(coefs.b1) * hist_x1
             + longint'(coefs.b2) * hist_x2) * (longint'(1) <<< HIST_FRAC)
            - longint'(coefs.a1) * hist_y1 - longint'(coefs.a2) * hist_y2;
      y = clamp_signed(round_half_up(acc, COEF_FRAC), HIST_W);
      r.value = sample_t'(clamp_signed(round_half_up(y, HIST_FRAC), SAMPLE_W));
    end
    hist_x2 = hist_x1;
    hist_x1 = xs;
    hist_y2 = hist_y1;
    hist_y1 = y;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall generator and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        // long hold-off, counted here in cycles
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
          STALL_PATTERN: out_stall <= stall_pattern[0];
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    filt_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (filtered_fifo.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0d] unexpected result: filtered_out=%0d warming_up=%0b",
                   cycle_count, filtered_out, warming_up);
      end else begin
        want = filtered_fifo.pop_front();
        results_checked++;
        if (filtered_out !== want.value || warming_up !== want.warm) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0d] result %0d: filtered_out exp %0d got %0d, warming_up exp %0b got %0b",
                     cycle_count, results_checked, want.value, filtered_out,
                     want.warm, warming_up);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // one sample request; valid stays high for the next one unless a gap is due
  task automatic send_sample(input sample_t x);
    int gap;
    if (gap_enable && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    in_valid  <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    filtered_fifo.push_back(biquad_step(x));
    samples_sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic wait_idle();
    if (in_valid !== 1'b0)
      in_valid <= 1'b0;
    burst_left = 0;
    while (filtered_fifo.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1)
      @(posedge clk);
    case (idx)
      REG_B0:  coefs.b0 = data;
      REG_B1:  coefs.b1 = data;
      REG_B2:  coefs.b2 = data;
      REG_A1:  coefs.a1 = data;
      REG_A2:  coefs.a2 = data;
      default: ;  // index past the list: ignored
    endcase
  endtask

  task automatic load_coefs(input coef_set_t s);
    wait_idle();
    write_reg(REG_B0, s.b0);
    write_reg(REG_B1, s.b1);
    write_reg(REG_B2, s.b2);
    write_reg(REG_A1, s.a1);
    write_reg(REG_A2, s.a2);
    cfg_valid <= 1'b0;
    coef_sets_loaded++;
  endtask

  function automatic sample_t rand_sample();
    return sample_t'($urandom_range(0, (1 << SAMPLE_W) - 1));
  endfunction

  // full range: any 18-bit pattern; otherwise within +/-1.0
  function automatic coef_set_t rand_coef_set(input bit full_range);
    coef_set_t s;
    logic [COEF_W-1:0] c [5];
    for (int i = 0; i < 5; i++) begin
      if (full_range)
        c[i] = COEF_W'($urandom_range(0, (1 << COEF_W) - 1));
      else
        c[i] = COEF_W'(int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE);
    end
    s = '{b0: c[0], b1: c[1], b2: c[2], a1: c[3], a2: c[4]};
    return s;
  endfunction

  // piecewise-constant sensor signal with noise, some raw noise in between
  task automatic run_sensor_stream(input int count);
    int level;
    int run;
    int v;
    level = 0;
    run = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_sample(rand_sample());
      end else begin
        if (run == 0) begin
          run = $urandom_range(4, 24);
          level = int'($urandom_range(0, (1 << SAMPLE_W) - 1)) + SMIN;
        end
        run--;
        v = level + int'($urandom_range(0, 1024)) - 512;
        if (v > SMAX)
          v = SMAX;
        if (v < SMIN)
          v = SMIN;
        send_sample(sample_t'(v));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // first WARMUP_LEN samples pass straight through with the flag set
  task automatic test_warmup();
    sample_t corners [7];
    corners = '{sample_t'(SMAX), sample_t'(SMIN), '0, '1, sample_t'(1),
                sample_t'(16'h5555), sample_t'(16'hAAAA)};
    stall_mode = STALL_RANDOM;
    foreach (corners[i])
      send_sample(corners[i]);
    for (int i = $size(corners); i < WARMUP_LEN; i++)
      send_sample(rand_sample());
  endtask

  // reset coefficients are b0 = 1.0, so the filter is the identity
  task automatic test_reset_coefs();
    stall_mode = STALL_PATTERN;
    send_sample(sample_t'(SMAX));
    send_sample(sample_t'(SMIN));
    send_sample('0);
    send_sample('1);
    for (int i = 0; i < 6; i++)
      send_sample(rand_sample());
  endtask

  // writes past the register list must leave the coefficients alone
  task automatic test_spare_index();
    wait_idle();
    for (int i = REG_A2 + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), COEF_W'($urandom_range(0, (1 << COEF_W) - 1)));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 6; i++)
      send_sample(rand_sample());
  endtask

  // b0 = 0.5: odd samples land exactly on a half at the output rounding
  task automatic test_half_rounding();
    load_coefs('{b0: COEF_W'(COEF_ONE / 2), b1: '0, b2: '0, a1: '0, a2: '0});
    send_sample(sample_t'(1));
    send_sample('1);
    send_sample(sample_t'(3));
    send_sample(sample_t'(-3));
    send_sample(sample_t'(SMAX));
    send_sample(sample_t'(SMIN + 1));
    send_sample(sample_t'(SMIN));
  endtask

  // gains beyond 1.0 and extreme feedback drive both clamps
  task automatic test_saturation();
    stall_mode = STALL_RANDOM;
    load_coefs('{b0: CMAX, b1: '0, b2: '0, a1: '0, a2: '0});
    send_sample(sample_t'(SMAX));
    send_sample(sample_t'(SMIN));
    send_sample(sample_t'(1000));
    send_sample(sample_t'(-1000));
    load_coefs('{b0: CMAX, b1: CMAX, b2: CMAX, a1: CMAX, a2: CMAX});
    send_sample(sample_t'(SMAX));
    send_sample(sample_t'(SMAX));
    send_sample(sample_t'(SMIN));
    send_sample('0);
    load_coefs('{b0: CMIN, b1: CMIN, b2: CMIN, a1: CMIN, a2: CMIN});
    send_sample(sample_t'(SMIN));
    send_sample(sample_t'(SMAX));
    send_sample(sample_t'(SMIN));
    send_sample('0);
  endtask

  // Butterworth low-pass sets at three cutoffs and one with a higher Q, sensor-like input
  task automatic test_lowpass_streams();
    coef_set_t lp [4];
    lp[0] = '{b0: 1105, b1: 2210, b2: 1105, a1: -18727, a2: 6763};   // fc = 0.10 fs
    lp[1] = '{b0: 4799, b1: 9598, b2: 4799, a1: 0, a2: 2811};        // fc = 0.25 fs
    lp[2] = '{b0: 59, b1: 119, b2: 59, a1: -29863, a2: 13717};       // fc = 0.02 fs
    lp[3] = '{b0: 2510, b1: 5020, b2: 2510, a1: -11720, a2: 5377};   // fc ~ 0.16 fs
    foreach (lp[i]) begin
      stall_mode = (i % 2 == 0) ? STALL_RANDOM : STALL_PATTERN;
      load_coefs(lp[i]);
      run_sensor_stream(60);
    end
  endtask

  // random coefficient sets, some of them unstable
  task automatic test_random_coefs();
    for (int i = 0; i < 5; i++) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      load_coefs(rand_coef_set(i % 2 == 0));
      for (int k = 0; k < 40; k++)
        send_sample(rand_sample());
    end
  endtask

  // result side holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    stall_mode = STALL_NONE;
    gap_enable = 1'b0;
    hold_request = 40;
    run_sensor_stream(30);
    stall_mode = STALL_RANDOM;
    hold_request = 25;
    run_sensor_stream(20);
    // sender pauses until everything has drained
    wait_idle();
    gap_enable = 1'b1;
  endtask

  // full rate, no gaps and no stalls
  task automatic test_steady_stream();
    load_coefs('{b0: 1105, b1: 2210, b2: 1105, a1: -18727, a2: 6763});
    stall_mode = STALL_NONE;
    gap_enable = 1'b0;
    run_sensor_stream(50);
    gap_enable = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_warmup();
    test_reset_coefs();
    test_spare_index();
    test_half_rounding();
    test_saturation();
    test_lowpass_streams();
    test_random_coefs();
    test_backpressure();
    test_steady_stream();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (filtered_fifo.size() != 0)
      mismatch_count += filtered_fifo.size();

    $display("covered %0d samples, %0d results checked, %0d coefficient sets",
             samples_sent, results_checked, coef_sets_loaded);
    $display("warm-up, reset coefs, spare indexes, rounding, clamps, back-pressure");
    if (mismatch_count == 0)
      $display("** biquad_lowpass_with_warmup_core: PASSED **");
    else
      $display("** biquad_lowpass_with_warmup_core: FAILED **");
    $finish;
  end

endmodule
